// File: hdl/q_learning_order_selector_macros.svh
`ifndef Q_LEARNING_ORDER_SELECTOR_MACROS_SVH
`define Q_LEARNING_ORDER_SELECTOR_MACROS_SVH

// same-cycle implication, checked on clk and masked while arst_n is low
`define QLOS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk and masked while arst_n is low
`define QLOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/qlos_pkg.sv
`timescale 1ns / 1ps

package qlos_pkg;

	// geometry
	localparam int NUM_ACTIONS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int ACT_W       = 5;
	localparam int MOVE_W      = 2;
	localparam int FX_W        = FRAC_BITS + 1;
	localparam int RAND_W      = 16;
	localparam int COST_W      = 24;
	localparam int Q_W         = 24;
	localparam int REWARD_W    = 18;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int MEM_DEPTH   = NUM_ACTIONS * NUM_ACTIONS;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	// stream payload widths, padded to whole bytes
	localparam int S_FIELDS_W = RAND_W + 2 * ACT_W + 2 * COST_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = ACT_W + 4 * MOVE_W + REWARD_W + Q_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [FX_W-1:0]   fx_t;
	typedef logic [MOVE_W-1:0] move_t;

	// transaction kinds on the input side
	localparam logic FUNC_SELECT = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_SELECTED   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UPDATED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_PENDING = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_EPSILON = 2'd2;

	// fixed-point constants
	localparam fx_t ONE_FX        = fx_t'(1 << FRAC_BITS);
	localparam fx_t LEARN_RATE_RST = fx_t'(((1 << FRAC_BITS) + 5) / 10);
	localparam fx_t DISCOUNT_RST   = fx_t'((9 * (1 << FRAC_BITS) + 5) / 10);
	localparam fx_t START_EPS_RST  = fx_t'((3 * (1 << FRAC_BITS) + 5) / 10);
	localparam fx_t EPS_FLOOR      = fx_t'((5 * (1 << FRAC_BITS) + 50) / 100);

	// reciprocal of ten for the epsilon decay: exact for every epsilon value
	localparam int  EPS_SHIFT = FRAC_BITS + 4;
	localparam fx_t EPS_RECIP = fx_t'(((1 << EPS_SHIFT) + 9) / 10);

	// the 24 orders of the four moves, first move at index 0
	localparam move_t MOVE_ORDERS [NUM_ACTIONS][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
		'{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
		'{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd2, 2'd1, 2'd0, 2'd3},
		'{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
		'{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd1, 2'd0, 2'd2},
		'{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
	};

	// fold a 5-bit index into the order range
	function automatic action_t mod_actions(input action_t v);
		return (v >= action_t'(NUM_ACTIONS)) ? v - action_t'(NUM_ACTIONS) : v;
	endfunction

	// flat address of q entry (row, col)
	function automatic logic [ADDR_W-1:0] row_addr(input action_t row, input action_t col);
		return ADDR_W'(row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col);
	endfunction

endpackage

// File: hdl/q_learning_order_selector.sv
// q_learning_order_selector: tabular q-learning choice of one of 24 move orders
// s_* channel: one transaction per request; s_tuser is the kind (select / report),
//   s_tdata carries the random draws and the costs before and after the order ran.
// m_* channel: exactly one result transaction per request; m_tuser is the status,
//   m_tdata the order index, its four moves, the reward and the new q entry.
// cfg_* channel: register writes (learn rate, discount, start epsilon), always ready,
//   values above one are stored as one; writing start epsilon reloads epsilon.
// after reset the 576-entry q memory is swept to zero, one entry a cycle, so the
//   block takes no request until the sweep is done (register writes still go in).
// work per request: select with exploration or report without a pending order goes
//   straight to the result; greedy select reads one memory entry per row entry through
//   the shared compare; report runs 16 restoring divide steps, a 24-entry row scan and
//   two passes through the shared multiplier, and skips the divide when none is needed.
// the result goes valid in the same cycle that s_tready returns.
// one request is in flight at a time; s_tready is high only while idle.
// the result sits in an output register, so the next request is taken while a
//   stalled result waits; the sequencer holds in its last step until m_tready frees it.
`timescale 1ns / 1ps

`include "q_learning_order_selector_macros.svh"

module q_learning_order_selector
	import qlos_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// rand_explore, rand_action, rand_start, cost_before, cost_after, zero pad
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// func
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// action, move_first, move_second, move_third, move_fourth, reward, new_q, zero pad
	output logic [M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [STATUS_W-1:0]    m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FX_W-1:0]        cfg_data
);

	// sequencer codes
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_PREP  = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_QREAD = 4'd5;
	localparam logic [3:0] ST_QWAIT = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_MUL2  = 4'd8;
	localparam logic [3:0] ST_UPD   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	// datapath widths
	localparam int TGT_W     = Q_W + 4;
	localparam int PROD_W    = FX_W + 1 + TGT_W;
	localparam int NQS_W     = PROD_W - FRAC_BITS + 1;
	localparam int REM_W     = COST_W + 1;
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);
	localparam int EPS_P_W   = EPS_SHIFT + FX_W;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

	// input field offsets in s_tdata
	localparam int OFS_RACT   = RAND_W;
	localparam int OFS_RSTART = OFS_RACT + ACT_W;
	localparam int OFS_BEFORE = OFS_RSTART + ACT_W;
	localparam int OFS_AFTER  = OFS_BEFORE + COST_W;

	logic [3:0]              state_q;
	logic [ADDR_W-1:0]       clr_addr_q;

	// configuration and learner state
	fx_t                     learn_rate_q;
	fx_t                     discount_q;
	fx_t                     start_eps_q;
	fx_t                     eps_q;
	action_t                 current_action_q;
	logic                    started_q;
	action_t                 pending_action_q;
	logic                    pending_valid_q;

	// per-request working registers
	logic                    func_q;
	logic [COST_W-1:0]       before_q;
	logic [COST_W-1:0]       after_q;
	logic                    neg_q;
	logic [REM_W-1:0]        rem_q;
	logic [FRAC_BITS-1:0]    quot_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic signed [REWARD_W-1:0] reward_q;
	action_t                 row_q;
	action_t                 scan_cnt_q;
	logic                    scan_vld_s1;
	action_t                 scan_idx_s1;
	logic signed [Q_W-1:0]   best_q;
	action_t                 best_idx_q;
	logic signed [Q_W-1:0]   max_next_q;
	logic signed [Q_W-1:0]   q_old_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [TGT_W-1:0] target_q;
	fx_t                     eps_tenth_q;

	// result and output registers
	action_t                 res_action_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [REWARD_W-1:0]     res_reward_q;
	logic [Q_W-1:0]          res_nq_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [STATUS_W-1:0]     m_tuser_q;

	// q memory
	logic signed [Q_W-1:0]   mem_q [MEM_DEPTH];
	logic signed [Q_W-1:0]   mem_rdata_q;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic signed [Q_W-1:0]   mem_wdata;
	logic                    mem_re;
	logic [ADDR_W-1:0]       mem_raddr;

	// combinational nets
	logic                    s_accept;
	logic [RAND_W-1:0]       in_rexp;
	action_t                 in_ract;
	action_t                 in_rstart;
	logic [COST_W-1:0]       in_before;
	logic [COST_W-1:0]       in_after;
	logic                    explore;
	action_t                 pick_rand;
	action_t                 cur_sel;
	fx_t                     cfg_clamped;
	logic [COST_W-1:0]       mag;
	logic [REM_W-1:0]        div_r2;
	logic                    div_ge;
	logic [FRAC_BITS-1:0]    quot_next;
	logic [REWARD_W-1:0]     quot_ext;
	logic                    scan_issue;
	logic                    scan_take;
	logic signed [Q_W-1:0]   scan_best;
	action_t                 scan_best_idx;
	logic                    scan_done;
	fx_t                     mul_a;
	logic signed [FX_W:0]    mul_a_ext;
	logic signed [TGT_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [TGT_W-1:0] reward_ext;
	logic signed [TGT_W-1:0] qold_tgt;
	logic signed [TGT_W-1:0] target_next;
	logic signed [NQS_W-1:0] qold_nqs;
	logic signed [NQS_W-1:0] nq_sum;
	logic [NQS_W-Q_W:0]      nq_top;
	logic signed [Q_W-1:0]   nq_sat;
	logic [FX_W:0]           eps_x;
	logic [EPS_P_W-1:0]      eps_p;
	fx_t                     eps_dec;
	fx_t                     eps_next;
	logic                    out_free;

	// ---------------------------------------------------------------- ports
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign in_rexp   = s_tdata[RAND_W-1:0];
	assign in_ract   = s_tdata[OFS_RACT +: ACT_W];
	assign in_rstart = s_tdata[OFS_RSTART +: ACT_W];
	assign in_before = s_tdata[OFS_BEFORE +: COST_W];
	assign in_after  = s_tdata[OFS_AFTER +: COST_W];

	// ---------------------------------------------------------------- select decision
	// exploration test compares q16 draw against epsilon at full precision
	assign explore = {1'b0, in_rexp, {FRAC_BITS{1'b0}}} < {eps_q, {RAND_W{1'b0}}};
	assign pick_rand = mod_actions(in_ract);
	assign cur_sel   = started_q ? current_action_q : mod_actions(in_rstart);

	assign cfg_clamped = (cfg_data > ONE_FX) ? ONE_FX : cfg_data;

	// ---------------------------------------------------------------- reward divider
	assign mag       = (before_q >= after_q) ? before_q - after_q : after_q - before_q;
	assign div_r2    = {rem_q[REM_W-2:0], 1'b0};
	assign div_ge    = div_r2 >= REM_W'(before_q);
	assign quot_next = {quot_q[FRAC_BITS-2:0], div_ge};
	assign quot_ext  = REWARD_W'(quot_next);

	// ---------------------------------------------------------------- row scan
	// first maximum wins: only a strictly larger entry replaces the best
	assign scan_issue    = (state_q == ST_SCAN) && (scan_cnt_q < action_t'(NUM_ACTIONS));
	assign scan_take     = (scan_idx_s1 == '0) || (mem_rdata_q > best_q);
	assign scan_best     = scan_take ? mem_rdata_q : best_q;
	assign scan_best_idx = scan_take ? scan_idx_s1 : best_idx_q;
	assign scan_done     = scan_vld_s1 && (scan_idx_s1 == action_t'(NUM_ACTIONS - 1));

	// ---------------------------------------------------------------- shared multiplier
	always_comb begin
		if (state_q == ST_MUL2) begin
			mul_a = learn_rate_q;
			mul_b = target_q;
		end else begin
			mul_a = discount_q;
			mul_b = {{(TGT_W-Q_W){max_next_q[Q_W-1]}}, max_next_q};
		end
	end
	assign mul_a_ext = {1'b0, mul_a};
	assign mul_p     = mul_a_ext * mul_b;

	// arithmetic shift is the floor division by one
	assign prod_sh     = prod_q >>> FRAC_BITS;
	assign reward_ext  = {{(TGT_W-REWARD_W){reward_q[REWARD_W-1]}}, reward_q};
	assign qold_tgt    = {{(TGT_W-Q_W){q_old_q[Q_W-1]}}, q_old_q};
	assign target_next = reward_ext + $signed(prod_sh[TGT_W-1:0]) - qold_tgt;

	assign qold_nqs = {{(NQS_W-Q_W){q_old_q[Q_W-1]}}, q_old_q};
	assign nq_sum   = $signed(prod_sh[NQS_W-1:0]) + qold_nqs;
	assign nq_top   = nq_sum[NQS_W-1:Q_W-1];

	// saturate to the q entry range
	always_comb begin
		if ((&nq_top) || !(|nq_top)) begin
			nq_sat = nq_sum[Q_W-1:0];
		end else if (nq_sum[NQS_W-1]) begin
			nq_sat = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			nq_sat = {1'b0, {(Q_W-1){1'b1}}};
		end
	end

	// ---------------------------------------------------------------- epsilon decay
	// floor(e * 9 / 10) = e - ceil(e / 10), the tenth through a reciprocal
	assign eps_x    = {1'b0, eps_q} + (FX_W+1)'(9);
	assign eps_p    = EPS_P_W'(eps_x) * EPS_P_W'(EPS_RECIP);
	assign eps_dec  = eps_q - eps_tenth_q;
	assign eps_next = (eps_dec < EPS_FLOOR) ? EPS_FLOOR : eps_dec;

	// ---------------------------------------------------------------- memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_addr(current_action_q, pending_action_q);
		mem_wdata = nq_sat;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_UPD: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re    = scan_issue || (state_q == ST_QREAD);
	assign mem_raddr = (state_q == ST_QREAD) ? row_addr(current_action_q, pending_action_q)
	                                         : row_addr(row_q, scan_cnt_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_addr_q       <= '0;
			learn_rate_q     <= LEARN_RATE_RST;
			discount_q       <= DISCOUNT_RST;
			start_eps_q      <= START_EPS_RST;
			eps_q            <= START_EPS_RST;
			current_action_q <= '0;
			started_q        <= 1'b0;
			pending_action_q <= '0;
			pending_valid_q  <= 1'b0;
			div_cnt_q        <= '0;
			scan_cnt_q       <= '0;
			scan_vld_s1      <= 1'b0;
			m_tvalid_q       <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_issue;
			// a new result replaces one taken in the same cycle
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					REG_LEARN_RATE: begin
						learn_rate_q <= cfg_clamped;
					end
					REG_DISCOUNT: begin
						discount_q <= cfg_clamped;
					end
					REG_START_EPSILON: begin
						start_eps_q <= cfg_clamped;
						eps_q       <= cfg_clamped;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						if (s_tuser == FUNC_SELECT) begin
							current_action_q <= cur_sel;
							started_q        <= 1'b1;
							if (explore) begin
								pending_action_q <= pick_rand;
								pending_valid_q  <= 1'b1;
								state_q          <= ST_OUT;
							end else begin
								scan_cnt_q <= '0;
								state_q    <= ST_SCAN;
							end
						end else if (!pending_valid_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					// zero earlier cost or a change of at least the whole cost: no divide
					if ((before_q == '0) || (mag >= before_q)) begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end else begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					if (scan_done) begin
						if (func_q == FUNC_SELECT) begin
							pending_action_q <= scan_best_idx;
							pending_valid_q  <= 1'b1;
							state_q          <= ST_OUT;
						end else begin
							state_q <= ST_QREAD;
						end
					end
				end
				ST_QREAD: begin
					state_q <= ST_QWAIT;
				end
				ST_QWAIT: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					current_action_q <= pending_action_q;
					pending_valid_q  <= 1'b0;
					eps_q            <= eps_next;
					state_q          <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					func_q       <= s_tuser;
					before_q     <= in_before;
					after_q      <= in_after;
					res_reward_q <= '0;
					res_nq_q     <= '0;
					if (s_tuser == FUNC_SELECT) begin
						row_q        <= cur_sel;
						res_action_q <= pick_rand;
						res_status_q <= STATUS_SELECTED;
					end else begin
						row_q        <= pending_action_q;
						res_action_q <= current_action_q;
						res_status_q <= STATUS_NO_PENDING;
					end
				end
			end
			ST_PREP: begin
				neg_q  <= after_q > before_q;
				rem_q  <= REM_W'(mag);
				quot_q <= '0;
				if (before_q == '0) begin
					reward_q <= '0;
				end else if (after_q > before_q) begin
					reward_q <= -$signed(REWARD_W'(ONE_FX));
				end else begin
					reward_q <= $signed(REWARD_W'(ONE_FX));
				end
			end
			ST_DIV: begin
				rem_q  <= div_ge ? div_r2 - REM_W'(before_q) : div_r2;
				quot_q <= quot_next;
				if (div_cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
					reward_q <= neg_q ? -$signed(quot_ext) : $signed(quot_ext);
				end
			end
			ST_SCAN: begin
				if (scan_vld_s1) begin
					best_q     <= scan_best;
					best_idx_q <= scan_best_idx;
				end
				if (scan_done) begin
					max_next_q   <= scan_best;
					res_action_q <= scan_best_idx;
				end
			end
			ST_QWAIT: begin
				q_old_q <= mem_rdata_q;
				prod_q  <= mul_p;
			end
			ST_SUM: begin
				target_q    <= target_next;
				eps_tenth_q <= eps_p[EPS_SHIFT +: FX_W];
			end
			ST_MUL2: begin
				prod_q <= mul_p;
			end
			ST_UPD: begin
				res_action_q <= pending_action_q;
				res_status_q <= STATUS_UPDATED;
				res_reward_q <= reward_q;
				res_nq_q     <= nq_sat;
			end
			ST_OUT: begin
				if (out_free) begin
					m_tuser_q <= res_status_q;
					m_tdata_q <= {{M_PAD_W{1'b0}}, res_nq_q, res_reward_q,
					              MOVE_ORDERS[res_action_q][3], MOVE_ORDERS[res_action_q][2],
					              MOVE_ORDERS[res_action_q][1], MOVE_ORDERS[res_action_q][0],
					              res_action_q};
				end
			end
			default: begin
			end
		endcase
		scan_idx_s1 <= scan_cnt_q;
	end

	// ---------------------------------------------------------------- checks
	`QLOS_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready, state_q != ST_IDLE, "accepted transaction left the sequencer idle")
	`QLOS_ASSERT_SAME(a_update_has_pending, state_q == ST_UPD, pending_valid_q, "q update without a pending order")
	`QLOS_ASSERT_SAME(a_current_in_range, 1'b1, current_action_q < action_t'(NUM_ACTIONS), "current order out of range")
	`QLOS_ASSERT_SAME(a_clear_blocks_io, state_q == ST_CLEAR, !s_tready && !m_tvalid, "traffic during q memory clear")
	`QLOS_ASSERT_NEXT(a_select_sets_pending, (state_q == ST_SCAN) && scan_done && (func_q == FUNC_SELECT), pending_valid_q, "greedy select did not mark a pending order")

endmodule

// File: bench/order_selector_checker.sv
`timescale 1ns / 1ps

module order_selector_checker
	import qlos_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// rand_explore, rand_action, rand_start, cost_before, cost_after, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// action, move_first, move_second, move_third, move_fourth, reward, new_q, zero pad
	input  logic [M_TDATA_W-1:0] m_tdata,
	// status
	input  logic [STATUS_W-1:0]  m_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FX_W-1:0]      cfg_data,
	output int                   mismatches,
	output int                   open_orders
);

	localparam int     RW_LSB    = ACT_W + 4 * MOVE_W;
	localparam int     NQ_LSB    = RW_LSB + REWARD_W;
	localparam longint ONE_L     = longint'(ONE_FX);
	localparam longint Q_TOP     = (longint'(1) <<< (Q_W - 1)) - 1;
	localparam longint Q_BOTTOM  = -(longint'(1) <<< (Q_W - 1));
	localparam int     MAX_LINES = 100;

	typedef struct packed {
		action_t                  action;
		move_t                    move_first;
		move_t                    move_second;
		move_t                    move_third;
		move_t                    move_fourth;
		logic [STATUS_W-1:0]      status;
		logic [REWARD_W-1:0]      reward;
		logic [Q_W-1:0]           new_q;
	} order_result_t;

	// shadow of the learner
	logic [FX_W-1:0]       alpha, gamma, eps_now;
	logic signed [Q_W-1:0] q_mem [MEM_DEPTH];
	action_t               cur_order, pend_order;
	logic                  started, pend_valid;
	order_result_t         awaited_orders [$];
	int                    result_idx;

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_LINES)
			$display("order check: result %0d: %s", result_idx, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	function automatic logic [FX_W-1:0] clamp_fx(input logic [FX_W-1:0] v);
		return (v > ONE_FX) ? ONE_FX : v;
	endfunction

	// first maximum of a row
	function automatic action_t best_in_row(input action_t row);
		action_t best = '0;
		for (int j = 1; j < NUM_ACTIONS; j++)
			if (q_mem[row * NUM_ACTIONS + j] > q_mem[row * NUM_ACTIONS + best])
				best = action_t'(j);
		return best;
	endfunction

	function automatic order_result_t order_of(input action_t a, input logic [STATUS_W-1:0] st,
			input logic [REWARD_W-1:0] rw, input logic [Q_W-1:0] nq);
		order_result_t r;
		r.action      = a;
		r.move_first  = MOVE_ORDERS[a][0];
		r.move_second = MOVE_ORDERS[a][1];
		r.move_third  = MOVE_ORDERS[a][2];
		r.move_fourth = MOVE_ORDERS[a][3];
		r.status      = st;
		r.reward      = rw;
		r.new_q       = nq;
		return r;
	endfunction

	// choice of an order on select, q update on report
	task automatic learn_and_choose(input logic func, input logic [RAND_W-1:0] rexp,
			input action_t ract, input action_t rstart, input logic [COST_W-1:0] prior,
			input logic [COST_W-1:0] after, output order_result_t res);
		action_t pick, cur, nxt;
		longint  gain, diff, mag, frac, best_next, q_old, target, nq;
		if (func == FUNC_SELECT) begin
			if (!started) begin
				cur_order = action_t'(rstart % NUM_ACTIONS);
				started   = 1'b1;
			end
			if ({1'b0, rexp} < eps_now)
				pick = action_t'(ract % NUM_ACTIONS);
			else
				pick = best_in_row(cur_order);
			pend_order = pick;
			pend_valid = 1'b1;
			res = order_of(pick, STATUS_SELECTED, '0, '0);
		end else if (!pend_valid) begin
			res = order_of(cur_order, STATUS_NO_PENDING, '0, '0);
		end else begin
			cur  = cur_order;
			nxt  = pend_order;
			gain = 0;
			if (prior != '0) begin
				diff = longint'(prior) - longint'(after);
				mag  = (diff < 0) ? -diff : diff;
				frac = (mag <<< FRAC_BITS) / longint'(prior);
				if (frac > ONE_L)
					frac = ONE_L;
				gain = (diff < 0) ? -frac : frac;
			end
			best_next = longint'(q_mem[nxt * NUM_ACTIONS + best_in_row(nxt)]);
			q_old     = longint'(q_mem[cur * NUM_ACTIONS + nxt]);
			target    = gain + ((longint'(gamma) * best_next) >>> FRAC_BITS) - q_old;
			nq        = q_old + ((longint'(alpha) * target) >>> FRAC_BITS);
			if (nq > Q_TOP)
				nq = Q_TOP;
			else if (nq < Q_BOTTOM)
				nq = Q_BOTTOM;
			q_mem[cur * NUM_ACTIONS + nxt] = nq[Q_W-1:0];
			cur_order  = nxt;
			pend_valid = 1'b0;
			eps_now    = FX_W'((longint'(eps_now) * 9) / 10);
			if (eps_now < EPS_FLOOR)
				eps_now = EPS_FLOOR;
			res = order_of(nxt, STATUS_UPDATED, gain[REWARD_W-1:0], nq[Q_W-1:0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		order_result_t want, seen;
		if (!arst_n) begin
			alpha      = LEARN_RATE_RST;
			gamma      = DISCOUNT_RST;
			eps_now    = START_EPS_RST;
			cur_order  = '0;
			pend_order = '0;
			started    = 1'b0;
			pend_valid = 1'b0;
			foreach (q_mem[i])
				q_mem[i] = '0;
			awaited_orders.delete();
			result_idx = 0;
			mismatches = 0;
			open_orders <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEARN_RATE: alpha = clamp_fx(cfg_data);
					REG_DISCOUNT: gamma = clamp_fx(cfg_data);
					REG_START_EPSILON: eps_now = clamp_fx(cfg_data);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				seen.action      = m_tdata[ACT_W-1:0];
				seen.move_first  = m_tdata[ACT_W + 0 * MOVE_W +: MOVE_W];
				seen.move_second = m_tdata[ACT_W + 1 * MOVE_W +: MOVE_W];
				seen.move_third  = m_tdata[ACT_W + 2 * MOVE_W +: MOVE_W];
				seen.move_fourth = m_tdata[ACT_W + 3 * MOVE_W +: MOVE_W];
				seen.reward      = m_tdata[RW_LSB +: REWARD_W];
				seen.new_q       = m_tdata[NQ_LSB +: Q_W];
				seen.status      = m_tuser;
				if (awaited_orders.size() == 0) begin
					report_mismatch("result transaction with nothing awaited");
				end else begin
					want = awaited_orders.pop_front();
					check_field("action", seen.action, want.action);
					check_field("move_first", seen.move_first, want.move_first);
					check_field("move_second", seen.move_second, want.move_second);
					check_field("move_third", seen.move_third, want.move_third);
					check_field("move_fourth", seen.move_fourth, want.move_fourth);
					check_field("status", seen.status, want.status);
					check_field("reward", seen.reward, want.reward);
					check_field("new_q", seen.new_q, want.new_q);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready) begin
				learn_and_choose(s_tuser, s_tdata[RAND_W-1:0], s_tdata[RAND_W +: ACT_W],
					s_tdata[RAND_W + ACT_W +: ACT_W], s_tdata[RAND_W + 2 * ACT_W +: COST_W],
					s_tdata[RAND_W + 2 * ACT_W + COST_W +: COST_W], want);
				awaited_orders.push_back(want);
			end
			open_orders <= awaited_orders.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import qlos_pkg::*;

	// generous bound: 2000 requests with both sides idling and the q memory sweep after
	// reset, taken several times over
	localparam int RUN_LIMIT    = 1000000;
	// a report is the longest request, so this covers any straggling result
	localparam int DRAIN_CYCLES = 128;
	localparam logic [COST_W-1:0]    COST_TOP   = '1;
	localparam logic [RAND_W-1:0]    FRAC_TOP   = '1;
	// index past the last register, expected to be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FX_W-1:0]      cfg_data;

	int mismatches;
	int open_orders;
	int cycle_cnt  = 0;
	int items_sent = 0;
	// per-phase idling odds in percent, sender side and receiver side
	int gap_pct    = 20;
	int stall_pct  = 20;

	q_learning_order_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// watches all three channels, predicts every result and counts mismatches
	order_selector_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.open_orders (open_orders)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side back-pressure: random bursts of stalled cycles
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(19, 1)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// one request transaction; valid stays up into the next request unless a gap is drawn
	task automatic push_request(input logic func, input logic [RAND_W-1:0] rexp,
			input action_t ract, input action_t rstart, input logic [COST_W-1:0] prior,
			input logic [COST_W-1:0] after);
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= S_TDATA_W'({after, prior, rstart, ract, rexp});
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// register write transaction; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FX_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [FX_W-1:0] lr, input logic [FX_W-1:0] dc,
			input logic [FX_W-1:0] eps, input logic spare);
		if (spare)
			write_reg(REG_SPARE, FX_W'($urandom));
		write_reg(REG_LEARN_RATE, lr);
		write_reg(REG_DISCOUNT, dc);
		write_reg(REG_START_EPSILON, eps);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and wait for every awaited result before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_orders != 0);
	endtask

	// cost pairs covering zero earlier cost, gains, losses past the clamp and no change
	task automatic draw_costs(output logic [COST_W-1:0] prior, output logic [COST_W-1:0] after);
		case ($urandom_range(5))
			0: begin
				prior = '0;
				after = COST_W'($urandom);
			end
			1: begin
				prior = COST_W'($urandom);
				after = COST_W'($urandom);
			end
			2: begin
				prior = COST_W'($urandom_range(1000));
				after = COST_W'($urandom_range(1000));
			end
			3: begin
				prior = COST_W'($urandom);
				after = '0;
			end
			4: begin
				prior = COST_W'($urandom_range(4000000));
				after = COST_W'(prior * 2 + $urandom_range(1000));
			end
			default: begin
				prior = COST_W'($urandom);
				after = prior;
			end
		endcase
	endtask

	// exploration draws: full range, or small values that land near epsilon
	function automatic logic [RAND_W-1:0] draw_fraction();
		return ($urandom_range(1) == 0) ? RAND_W'($urandom) : RAND_W'($urandom_range(25000));
	endfunction

	// mostly a select followed by its report; the rest lone reports and lone selects
	task automatic run_phase(input int count);
		int target;
		int kind;
		logic [COST_W-1:0] prior, after;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 80 || kind >= 90) begin
				draw_costs(prior, after);
				push_request(FUNC_SELECT, draw_fraction(), action_t'($urandom_range(31)),
					action_t'($urandom_range(31)), prior, after);
			end
			if (kind < 90) begin
				draw_costs(prior, after);
				push_request(FUNC_REPORT, draw_fraction(), action_t'($urandom_range(31)),
					action_t'($urandom_range(31)), prior, after);
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= FUNC_SELECT;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_LEARN_RATE;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings; the block sweeps its q memory first
		// report before any select: no pending order
		push_request(FUNC_REPORT, FRAC_TOP, 5'd31, 5'd31, COST_TOP, COST_TOP);
		// first select: start index out of range folds, explore with folded index
		push_request(FUNC_SELECT, '0, 5'd24, 5'd31, '0, COST_TOP);
		// zero earlier cost gives no reward
		push_request(FUNC_REPORT, '0, '0, '0, '0, 24'd5);
		// greedy select, then full gain
		push_request(FUNC_SELECT, FRAC_TOP, 5'd31, '0, COST_TOP, '0);
		push_request(FUNC_REPORT, FRAC_TOP, 5'd31, 5'd31, COST_TOP, '0);
		// pending order replaced by a second select
		push_request(FUNC_SELECT, '0, 5'd31, 5'd17, '0, '0);
		push_request(FUNC_SELECT, '0, 5'd23, 5'd3, '0, '0);
		// loss far past the clamp
		push_request(FUNC_REPORT, 16'h1234, 5'd9, 5'd9, 24'd1, COST_TOP);
		// report right after a report
		push_request(FUNC_REPORT, '0, '0, '0, 24'd100, 24'd50);
		push_request(FUNC_SELECT, FRAC_TOP, '0, '0, '0, '0);
		push_request(FUNC_REPORT, '0, '0, '0, 24'd100, 24'd150);
		push_request(FUNC_SELECT, '0, 5'd12, 5'd12, '0, '0);
		push_request(FUNC_REPORT, '0, '0, '0, COST_TOP, COST_TOP);
		push_request(FUNC_SELECT, 16'h8000, 5'd1, 5'd30, 24'hAAAAAA, 24'h555555);
		push_request(FUNC_REPORT, 16'h7FFF, 5'd30, 5'd1, 24'd3, 24'd1);
		push_request(FUNC_SELECT, 16'h4CCC, 5'd16, 5'd15, 24'h555555, 24'hAAAAAA);
		push_request(FUNC_REPORT, 16'h4CCD, 5'd15, 5'd16, 24'hAAAAAA, 24'h555555);

		// full learn rate and discount, no exploration: q climbs into saturation
		settle();
		load_settings(ONE_FX, ONE_FX, '0, 1'b0);
		repeat (200) begin
			push_request(FUNC_SELECT, FRAC_TOP, action_t'($urandom_range(31)),
				action_t'($urandom_range(31)), COST_W'($urandom), COST_W'($urandom));
			push_request(FUNC_REPORT, RAND_W'($urandom), action_t'($urandom_range(31)),
				action_t'($urandom_range(31)), 24'd1000, '0);
		end

		// learning off, epsilon written above one (stored as one), spare index poked
		settle();
		gap_pct   = $urandom_range(40);
		stall_pct = $urandom_range(40);
		load_settings('0, '0, '1, 1'b1);
		run_phase(400);

		// any 17-bit values, clamping included
		settle();
		gap_pct   = 0;
		stall_pct = $urandom_range(60, 20);
		load_settings(FX_W'($urandom), FX_W'($urandom), FX_W'($urandom), 1'b0);
		run_phase(400);

		// random settings within range
		settle();
		gap_pct   = $urandom_range(60, 20);
		stall_pct = 0;
		load_settings(FX_W'($urandom_range(ONE_FX)), FX_W'($urandom_range(ONE_FX)),
			FX_W'($urandom_range(ONE_FX)), 1'b1);
		run_phase(400);

		// closing stretch at reset values, both sides flat out
		settle();
		gap_pct   = 0;
		stall_pct = 0;
		load_settings(LEARN_RATE_RST, DISCOUNT_RST, START_EPS_RST, 1'b0);
		run_phase(400);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/qlos_pkg.sv
hdl/q_learning_order_selector.sv
bench/order_selector_checker.sv
bench/tb_top.sv
